### sv/pss_pkg.sv
package pss_pkg;

  localparam int NUM_SLOTS_DEF = 128;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_STATS  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] TYPE_ENERGY = 3'd2;
  localparam logic [2:0] TYPE_MAX    = 3'd4;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ALERT    = 2'd1;
  localparam logic [1:0] STATUS_CRITICAL = 2'd2;

  localparam logic [7:0] ACTIVE_RESET = 8'd100;

  localparam logic [6:0] DIV_STEPS = 7'd64;
  localparam logic [6:0] MUL_STEPS = 7'd33;

  typedef enum logic {
    ALU_DIV,
    ALU_MUL
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic [31:0]        count;
    logic signed [31:0] mean;
    logic [63:0]        sdev;
    logic signed [47:0] sum;
    logic [2:0]         kind;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_DSTART,
    ST_DWAIT,
    ST_MSTART,
    ST_MWAIT,
    ST_VSTART,
    ST_VWAIT,
    ST_OUT
  } state_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    begin
      s = {a[47], a} + {{17{b[31]}}, b};
      if (s[48] != s[47]) begin
        sat_add48 = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        sat_add48 = s[47:0];
      end
    end
  endfunction

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    begin
      sat_inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    end
  endfunction

endpackage

### sv/pss_alu.sv
module pss_alu (
  input  logic              clk,
  input  logic              rst,
  input  pss_pkg::alu_req_t req,
  input  logic [63:0]       op_a,
  input  logic [32:0]       op_b,
  output logic              done,
  output logic [65:0]       result
);
  import pss_pkg::*;

  alu_op_t     mode;
  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] sh;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [65:0] mc;
  logic [65:0] acc;
  logic [32:0] shifted;
  logic [33:0] diff;

  // Restoring division: one quotient bit per cycle, dividend shifts out of sh.
  assign shifted = {rem, sh[63]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == ALU_DIV) ? DIV_STEPS : MUL_STEPS;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.op;
      sh   <= op_a;
      rem  <= '0;
      dvs  <= op_b[31:0];
      mc   <= {33'd0, op_b};
      acc  <= '0;
    end else if (busy) begin
      if (mode == ALU_DIV) begin
        if (!diff[33]) begin
          rem <= diff[31:0];
          sh  <= {sh[62:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          sh  <= {sh[62:0], 1'b0};
        end
      end else begin
        if (sh[0]) begin
          acc <= acc + mc;
        end
        mc <= {mc[64:0], 1'b0};
        sh <= {1'b0, sh[63:1]};
      end
    end
  end

  assign result = (mode == ALU_DIV) ? {2'b00, sh} : acc;

endmodule

### sv/pss_table.sv
module pss_table #(
  parameter int NUM_SLOTS = pss_pkg::NUM_SLOTS_DEF,
  parameter int ADDR_W    = $clog2(NUM_SLOTS)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  addr,
  input  pss_pkg::entry_t    wdata,
  output pss_pkg::entry_t    rdata
);
  import pss_pkg::*;

  entry_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

### sv/per_sensor_running_statistics.sv
// Channel  Direction  Handshake              Contents
// in       input      in_valid / in_stall    operation, sensor_id, sensor_type, reading,
//                                            status_code
// out      output     out_valid / out_stall  result_kind, slot fields, global totals
// cfg      input      cfg_valid / cfg_ready  cfg_data = active_sensors
//
// A sample runs a 64-step divide for the new mean, a 33-step multiply for the
// squared deviation and a 64-step divide for the variance, all on the one shared
// shift-and-add unit. A read runs only the variance divide, and none for an empty
// slot; an error runs none. A report runs it for every slot that has readings.
// After reset every slot of the table is cleared before in_stall drops.
// A stalled result holds the block; the next transaction is taken once it leaves.
module per_sensor_running_statistics #(
  parameter int NUM_SLOTS = pss_pkg::NUM_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         operation,
  input  logic [7:0]         sensor_id,
  input  logic [2:0]         sensor_type,
  input  logic signed [31:0] reading,
  input  logic [1:0]         status_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         result_kind,
  output logic [7:0]         slot_index,
  output logic [2:0]         slot_type,
  output logic [31:0]        slot_count,
  output logic signed [31:0] slot_mean,
  output logic signed [47:0] slot_sum,
  output logic [47:0]        slot_variance,
  output logic [31:0]        ok_total,
  output logic [31:0]        alert_total,
  output logic [31:0]        critical_total,
  output logic signed [47:0] energy_total,
  output logic [7:0]         distinct_sensors,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import pss_pkg::*;

  localparam int ADDR_W = $clog2(NUM_SLOTS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_SLOTS - 1);

  state_t state, state_next;

  logic [7:0]  active;
  logic [31:0] ok_count, alert_count, critical_count;
  logic [47:0] energy_acc;
  logic [7:0]  seen;

  logic [1:0]  op_r;
  logic [7:0]  id_r;
  logic [2:0]  type_r;
  logic [31:0] x_r;
  logic [1:0]  status_r;

  logic [ADDR_W-1:0] addr;
  entry_t      e, rdata, e_new, wdata;
  logic        we;
  logic [32:0] delta_r;
  logic [31:0] n_r;
  logic [33:0] mean_new_r;

  entry_t            best_e;
  logic [ADDR_W-1:0] best_idx;
  logic [47:0]       best_var;
  logic              found;

  logic [1:0]  o_kind;
  logic [7:0]  o_idx;
  entry_t      o_e;
  logic [47:0] o_var;

  alu_req_t    req;
  logic [63:0] alu_a;
  logic [32:0] alu_b;
  logic        alu_done;
  logic [65:0] alu_res;

  logic        accept, in_err, in_range, fin, take;
  logic [32:0] delta_c, delta_abs_c, delta_mag;
  logic [31:0] n_c;
  logic [32:0] q;
  logic [33:0] q_signed, mean_new_c, d2_c, d2_abs;
  logic [64:0] sdev_sum;
  logic [47:0] var_c;

  pss_table #(.NUM_SLOTS(NUM_SLOTS), .ADDR_W(ADDR_W)) u_table (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  pss_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .op_a   (alu_a),
    .op_b   (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  assign in_range = (sensor_id < active) && (32'(sensor_id) < NUM_SLOTS);
  always_comb begin
    case (operation)
      OP_SAMPLE: in_err = !in_range || (sensor_type > TYPE_MAX) ||
                          (status_code > STATUS_CRITICAL);
      OP_READ:   in_err = !in_range;
      OP_REPORT: in_err = 1'b0;
      default:   in_err = 1'b1;
    endcase
  end

  // Welford arithmetic around the shared unit.
  assign delta_c     = {x_r[31], x_r} - {e.mean[31], e.mean};
  assign delta_abs_c = delta_c[32] ? -delta_c : delta_c;
  assign n_c         = sat_inc32(e.count);
  assign delta_mag   = delta_r[32] ? -delta_r : delta_r;
  assign q           = alu_res[32:0];
  assign q_signed    = delta_r[32] ? -{1'b0, q} : {1'b0, q};
  assign mean_new_c  = {{2{e.mean[31]}}, e.mean} + q_signed;
  assign d2_c        = {{2{x_r[31]}}, x_r} - mean_new_r;
  assign d2_abs      = d2_c[33] ? -d2_c : d2_c;
  assign sdev_sum    = {1'b0, e.sdev} + {15'd0, alu_res[65:16]};

  always_comb begin
    e_new.count = n_r;
    e_new.mean  = mean_new_r[31:0];
    e_new.sdev  = sdev_sum[64] ? {64{1'b1}} : sdev_sum[63:0];
    e_new.sum   = sat_add48(e.sum, x_r);
    e_new.kind  = (e.count == 32'd0) ? type_r : e.kind;
  end

  always_comb begin
    if (state == ST_VWAIT) begin
      var_c = (|alu_res[63:48]) ? {48{1'b1}} : alu_res[47:0];
    end else begin
      var_c = '0;
    end
  end

  // A variance is ready either from the unit or at once for an empty slot.
  assign fin  = ((state == ST_VSTART) && (e.count == 32'd0)) ||
                ((state == ST_VWAIT) && alu_done);
  assign take = (e.count != 32'd0) && (!found || (var_c > best_var));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    we         = 1'b0;
    wdata      = e_new;
    req.start  = 1'b0;
    req.op     = ALU_DIV;
    alu_a      = {e.sdev};
    alu_b      = {1'b0, e.count};
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = in_err ? ST_OUT : ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_LOAD;
      ST_LOAD:  state_next = (op_r == OP_SAMPLE) ? ST_DSTART : ST_VSTART;
      ST_DSTART: begin
        req.start  = 1'b1;
        alu_a      = {31'd0, delta_abs_c};
        alu_b      = {1'b0, n_c};
        state_next = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (alu_done) begin
          state_next = ST_MSTART;
        end
      end
      ST_MSTART: begin
        req.start  = 1'b1;
        req.op     = ALU_MUL;
        alu_a      = {31'd0, delta_mag};
        alu_b      = d2_abs[32:0];
        state_next = ST_MWAIT;
      end
      ST_MWAIT: begin
        if (alu_done) begin
          we         = 1'b1;
          state_next = ST_VSTART;
        end
      end
      ST_VSTART: begin
        if (e.count != 32'd0) begin
          req.start  = 1'b1;
          state_next = ST_VWAIT;
        end
      end
      ST_VWAIT: ;
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (fin) begin
      if (op_r == OP_REPORT && addr != LAST_ADDR) begin
        state_next = ST_FETCH;
      end else begin
        state_next = ST_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= ACTIVE_RESET;
      ok_count       <= '0;
      alert_count    <= '0;
      critical_count <= '0;
      energy_acc     <= '0;
      seen           <= '0;
      addr           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        addr <= addr + 1'b1;
      end
      if (accept) begin
        addr <= (operation == OP_REPORT) ? '0 : ADDR_W'(sensor_id);
      end
      if (fin && op_r == OP_REPORT && addr != LAST_ADDR) begin
        addr <= addr + 1'b1;
      end
      if (state == ST_MWAIT && alu_done) begin
        if (e.count == 32'd0 && seen != 8'hFF) begin
          seen <= seen + 8'd1;
        end
        if (type_r == TYPE_ENERGY) begin
          energy_acc <= sat_add48(energy_acc, x_r);
        end
        case (status_r)
          STATUS_OK:       ok_count       <= sat_inc32(ok_count);
          STATUS_ALERT:    alert_count    <= sat_inc32(alert_count);
          STATUS_CRITICAL: critical_count <= sat_inc32(critical_count);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= operation;
      id_r     <= sensor_id;
      type_r   <= sensor_type;
      x_r      <= reading;
      status_r <= status_code;
      best_e   <= '0;
      best_idx <= '0;
      best_var <= '0;
      found    <= 1'b0;
      if (in_err) begin
        o_kind <= KIND_ERROR;
        o_idx  <= sensor_id;
        o_e    <= '0;
        o_var  <= '0;
      end
    end
    if (state == ST_LOAD) begin
      e <= rdata;
    end
    if (state == ST_DSTART) begin
      delta_r <= delta_c;
      n_r     <= n_c;
    end
    if (state == ST_DWAIT && alu_done) begin
      mean_new_r <= mean_new_c;
    end
    if (state == ST_MWAIT && alu_done) begin
      e <= e_new;
    end
    if (fin) begin
      if (op_r == OP_REPORT) begin
        if (take) begin
          best_e   <= e;
          best_idx <= addr;
          best_var <= var_c;
          found    <= 1'b1;
        end
        o_kind <= KIND_REPORT;
        o_idx  <= take ? 8'(addr) : 8'(best_idx);
        o_e    <= take ? e : best_e;
        o_var  <= take ? var_c : best_var;
      end else begin
        o_kind <= (op_r == OP_SAMPLE) ? KIND_SAMPLE : KIND_STATS;
        o_idx  <= id_r;
        o_e    <= e;
        o_var  <= var_c;
      end
    end
  end

  assign result_kind      = o_kind;
  assign slot_index       = o_idx;
  assign slot_type        = o_e.kind;
  assign slot_count       = o_e.count;
  assign slot_mean        = o_e.mean;
  assign slot_sum         = o_e.sum;
  assign slot_variance    = o_var;
  assign ok_total         = ok_count;
  assign alert_total      = alert_count;
  assign critical_total   = critical_count;
  assign energy_total     = energy_acc;
  assign distinct_sensors = seen;

endmodule
